// ===== design/rrbd_pkg.sv =====
// ----------------------------------------------------------------------------
// rrbd_pkg: shared constants and types of the receive batch deframer
// Channel widths, transfer size limit and register map of the block.
// ----------------------------------------------------------------------------
`default_nettype none

package rrbd_pkg;

   // Largest transfer the deframer accepts; longer lengths saturate to it.
   localparam int unsigned MAX_TRANSFER_BYTES = 16384;

   // Fixed field widths of the channels.
   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TLEN_W    = 15;
   localparam int unsigned WORD_W    = 32;
   localparam int unsigned HDR_BYTES = 16;

   // Bytes left in a transfer: 0 .. MAX_TRANSFER_BYTES.
   localparam int unsigned TL_W  = $clog2(MAX_TRANSFER_BYTES + 1);
   // Position inside a message: below MAX_TRANSFER_BYTES + HDR_BYTES.
   localparam int unsigned POS_W = $clog2(MAX_TRANSFER_BYTES + HDR_BYTES);

   // Register port.
   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;
   // Register index is taken from the word address bit.
   localparam logic        REG_PACKET_MSG_TYPE = 1'b0;

   typedef logic [BYTE_W-1:0]     byte_type;
   typedef logic [TLEN_W-1:0]     tlen_type;
   typedef logic [WORD_W-1:0]     word_type;
   typedef logic [CSR_ADDR_W-1:0] csr_addr_type;
   typedef logic [CSR_DATA_W-1:0] csr_data_type;

endpackage

`default_nettype wire

// ===== design/rrbd_req_if.sv =====
// ----------------------------------------------------------------------------
// rrbd_req_if: transfer byte channel
// Carries one byte of a received transfer per item with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrbd_req_if;
   import rrbd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type data_byte;
   logic     first_of_transfer;
   tlen_type transfer_length;

   modport source (output valid, output data_byte, output first_of_transfer,
                   output transfer_length, input ready);
   modport sink   (input valid, input data_byte, input first_of_transfer,
                   input transfer_length, output ready);
endinterface

`default_nettype wire

// ===== design/rrbd_rsp_if.sv =====
// ----------------------------------------------------------------------------
// rrbd_rsp_if: payload byte channel
// Each item carries one payload byte, an empty-packet marker or an error.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrbd_rsp_if;
   import rrbd_pkg::*;

   logic     valid;
   logic     ready;
   byte_type out_byte;
   logic     byte_valid;
   logic     last_of_packet;
   logic     frame_error;
   word_type error_count;

   modport source (output valid, output out_byte, output byte_valid,
                   output last_of_packet, output frame_error,
                   output error_count, input ready);
   modport sink   (input valid, input out_byte, input byte_valid,
                   input last_of_packet, input frame_error,
                   input error_count, output ready);
endinterface

`default_nettype wire

// ===== design/rndis_rx_batch_deframer_top.sv =====
// ----------------------------------------------------------------------------
// rndis_rx_batch_deframer_top: batched packet message deframer
// Splits a received transfer into payload bytes, one per cycle unless stalled.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries the transfer one byte per item; first_of_transfer marks
//   the first byte and then transfer_length gives the byte count (0 counts
//   as 1, larger than MAX_TRANSFER_BYTES saturates). Each message opens with
//   a 16-byte header (type, message length, data offset, data length, all
//   little endian). rsp_ch carries each payload byte with byte_valid set,
//   last_of_packet on the final byte, or a single marker item for an empty
//   payload. A bad header, a transfer ending in a header or a payload start
//   inside the header gives one item with frame_error set; the rest of the
//   transfer is then dropped. error_count is the running error count.
//   The APB port holds packet_msg_type at address 0 (reset 1).
// Timing:
//   A result shows in the cycle after its byte is accepted. One byte is
//   taken every cycle; the only limit is the single output register, which
//   blocks a new byte only while its item waits on rsp_ch.ready.
// Reset:
//   Synchronous reset returns to idle, clears the error count and empties
//   the output register; bytes without first_of_transfer are then ignored.
// ----------------------------------------------------------------------------
`default_nettype none

module rndis_rx_batch_deframer_top (
   input  wire                   clock,
   input  wire                   reset,
   rrbd_req_if.sink              req_ch,
   rrbd_rsp_if.source            rsp_ch,
   input  wire                   psel,
   input  wire                   penable,
   input  wire                   pwrite,
   input  rrbd_pkg::csr_addr_type paddr,
   input  rrbd_pkg::csr_data_type pwdata,
   output rrbd_pkg::csr_data_type prdata,
   output logic                  pready
);
   import rrbd_pkg::*;

   typedef enum logic [3:0] {
      PH_IDLE    = 4'b0001,
      PH_HEADER  = 4'b0010,
      PH_BODY    = 4'b0100,
      PH_DISCARD = 4'b1000
   } phase_type;

   // Configuration
   word_type cfg_type_ff;

   // Deframer state
   phase_type        phase_ff, phase_in;
   logic [TL_W-1:0]  tl_ff, tl_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   word_type         htype_ff, htype_in;
   word_type         mlen_ff, mlen_in;
   word_type         offs_ff, offs_in;
   word_type         plen_ff, plen_in;
   logic [POS_W-1:0] pstart_ff, pstart_in;
   logic [POS_W-1:0] pend_ff, pend_in;
   word_type         errs_ff, errs_in;

   // Output register
   logic     rsp_valid_ff;
   byte_type rsp_byte_ff;
   logic     rsp_bval_ff;
   logic     rsp_last_ff;
   logic     rsp_err_ff;
   word_type rsp_cnt_ff;

   // Result of the current byte
   logic     res_fire;
   byte_type res_byte;
   logic     res_bval;
   logic     res_last;
   logic     res_err;

   // Working values
   logic             accept;
   logic [TL_W-1:0]  tlen_clamped;
   phase_type        ph_eff;
   logic [TL_W-1:0]  tl_eff;
   logic [POS_W-1:0] pos_eff;
   logic [TL_W-1:0]  tl_dec;
   logic             xfer_done;
   logic [3:0]       hpos;
   logic [1:0]       hword;
   logic [1:0]       hlane;
   logic [POS_W-1:0] avail;
   logic [WORD_W+1:0] need;
   logic [WORD_W:0]  start_wide;
   logic             hdr_bad;
   logic             raise;
   logic [POS_W:0]   pos_inc;
   logic             csr_wr;

   assign accept       = req_ch.valid && req_ch.ready;
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;

   // Register port: index decoded from the word address bit.
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && (paddr[2] == REG_PACKET_MSG_TYPE);
   assign prdata = (paddr[2] == REG_PACKET_MSG_TYPE) ? cfg_type_ff : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_type_ff <= word_type'(1);
      end else if (csr_wr) begin
         cfg_type_ff <= pwdata;
      end
   end

   // Clamp the transfer length into 1 .. MAX_TRANSFER_BYTES.
   always_comb begin
      if (req_ch.transfer_length == '0) begin
         tlen_clamped = TL_W'(1);
      end else if (32'(req_ch.transfer_length) > 32'(MAX_TRANSFER_BYTES)) begin
         tlen_clamped = TL_W'(MAX_TRANSFER_BYTES);
      end else begin
         tlen_clamped = TL_W'(req_ch.transfer_length);
      end
   end

   // A first byte restarts at a message header.
   assign ph_eff  = req_ch.first_of_transfer ? PH_HEADER : phase_ff;
   assign tl_eff  = req_ch.first_of_transfer ? tlen_clamped : tl_ff;
   assign pos_eff = req_ch.first_of_transfer ? '0 : pos_ff;

   assign tl_dec    = tl_eff - TL_W'(1);
   assign xfer_done = (tl_dec == '0);
   assign hpos      = pos_eff[3:0];
   assign hword     = hpos[3:2];
   assign hlane     = hpos[1:0];
   assign avail     = POS_W'(HDR_BYTES) + POS_W'(tl_dec);
   assign pos_inc   = {1'b0, pos_eff} + (POS_W+1)'(1);

   // Header checks use the length word with its final byte merged in.
   assign start_wide = {1'b0, offs_ff} + (WORD_W+1)'(8);
   assign need       = {1'b0, start_wide} + {2'b00, plen_in};
   assign hdr_bad    = (htype_ff != cfg_type_ff)
                    || (mlen_ff > WORD_W'(avail))
                    || (need > {2'b00, mlen_ff})
                    || (offs_ff < WORD_W'(8));

   always_comb begin
      phase_in  = phase_ff;
      tl_in     = tl_ff;
      pos_in    = pos_ff;
      htype_in  = htype_ff;
      mlen_in   = mlen_ff;
      offs_in   = offs_ff;
      plen_in   = plen_ff;
      pstart_in = pstart_ff;
      pend_in   = pend_ff;
      errs_in   = errs_ff;
      res_fire  = 1'b0;
      res_byte  = '0;
      res_bval  = 1'b0;
      res_last  = 1'b0;
      res_err   = 1'b0;
      raise     = 1'b0;

      if (accept) begin
         if (ph_eff == PH_IDLE || tl_eff == '0) begin
            // Stray byte outside a transfer: drop it.
            phase_in = PH_IDLE;
            tl_in    = tl_eff;
         end else begin
            phase_in = ph_eff;
            tl_in    = tl_dec;
            pos_in   = pos_eff;
            case (ph_eff)
               PH_DISCARD: begin
                  if (xfer_done) begin
                     phase_in = PH_IDLE;
                  end
               end
               PH_HEADER: begin
                  case (hword)
                     2'd0:    htype_in[8*hlane +: 8] = req_ch.data_byte;
                     2'd1:    mlen_in[8*hlane +: 8]  = req_ch.data_byte;
                     2'd2:    offs_in[8*hlane +: 8]  = req_ch.data_byte;
                     default: plen_in[8*hlane +: 8]  = req_ch.data_byte;
                  endcase
                  if (hpos != 4'hF) begin
                     pos_in = pos_inc[POS_W-1:0];
                     if (xfer_done) begin
                        raise = 1'b1;
                     end
                  end else if (hdr_bad) begin
                     raise = 1'b1;
                  end else begin
                     // Header good: payload bounds fit within the message.
                     pstart_in = start_wide[POS_W-1:0];
                     pend_in   = need[POS_W-1:0];
                     if (mlen_ff == WORD_W'(HDR_BYTES)) begin
                        pos_in   = '0;
                        phase_in = xfer_done ? PH_IDLE : PH_HEADER;
                     end else begin
                        pos_in   = POS_W'(HDR_BYTES);
                        phase_in = xfer_done ? PH_IDLE : PH_BODY;
                     end
                     if (plen_in == '0) begin
                        res_fire = 1'b1;
                        res_last = 1'b1;
                     end
                  end
               end
               PH_BODY: begin
                  if (pos_eff >= pstart_ff && pos_eff < pend_ff) begin
                     res_fire = 1'b1;
                     res_byte = req_ch.data_byte;
                     res_bval = 1'b1;
                     res_last = (pos_inc == {1'b0, pend_ff});
                  end
                  // Advance to the next message at message length.
                  if (pos_inc >= mlen_ff[POS_W:0]) begin
                     pos_in   = '0;
                     phase_in = xfer_done ? PH_IDLE : PH_HEADER;
                  end else begin
                     pos_in = pos_inc[POS_W-1:0];
                     if (xfer_done) begin
                        phase_in = PH_IDLE;
                     end
                  end
               end
               default: begin
                  phase_in = PH_IDLE;
               end
            endcase
            if (raise) begin
               errs_in  = errs_ff + WORD_W'(1);
               phase_in = xfer_done ? PH_IDLE : PH_DISCARD;
               pos_in   = '0;
               res_fire = 1'b1;
               res_err  = 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         tl_ff    <= '0;
         pos_ff   <= '0;
         errs_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         tl_ff    <= tl_in;
         pos_ff   <= pos_in;
         errs_ff  <= errs_in;
      end
   end

   always_ff @(posedge clock) begin
      htype_ff  <= htype_in;
      mlen_ff   <= mlen_in;
      offs_ff   <= offs_in;
      plen_ff   <= plen_in;
      pstart_ff <= pstart_in;
      pend_ff   <= pend_in;
   end

   // Output register: load a new item, hold while stalled.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         rsp_byte_ff <= res_byte;
         rsp_bval_ff <= res_bval;
         rsp_last_ff <= res_last;
         rsp_err_ff  <= res_err;
         rsp_cnt_ff  <= errs_in;
      end
   end

   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.out_byte       = rsp_byte_ff;
   assign rsp_ch.byte_valid     = rsp_bval_ff;
   assign rsp_ch.last_of_packet = rsp_last_ff;
   assign rsp_ch.frame_error    = rsp_err_ff;
   assign rsp_ch.error_count    = rsp_cnt_ff;

endmodule

`default_nettype wire

// ===== verif/rrbd_payload_checker.sv =====
// ----------------------------------------------------------------------------
// rrbd_payload_checker: payload predictor and checker for the batch deframer
// Watches the transfer byte channel, the payload channel and the register
// bus. Runs its own deframer on every accepted byte, queues the payload,
// marker and error items it foresees, and compares each item on the payload
// channel with the oldest one queued.
// ----------------------------------------------------------------------------
`default_nettype none

module rrbd_payload_checker (
   input  wire                    clock,
   input  wire                    reset,
   rrbd_req_if                    req_mon,
   rrbd_rsp_if                    rsp_mon,
   input  wire                    psel,
   input  wire                    penable,
   input  wire                    pwrite,
   input  wire                    pready,
   input  rrbd_pkg::csr_addr_type paddr,
   input  rrbd_pkg::csr_data_type pwdata,
   output int unsigned            fail_count,
   output int unsigned            pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import rrbd_pkg::*;

   typedef enum logic [1:0] {ST_WAIT, ST_HDR, ST_PAYLOAD, ST_DROP} deframe_state_type;

   typedef struct packed {
      byte_type data;
      logic     is_byte;
      logic     last;
      logic     fault;
      word_type errors;
   } payload_item_type;

   payload_item_type   expected_items[$];

   word_type          cfg_msg_type;
   deframe_state_type state;
   logic [TL_W-1:0]   bytes_left;
   word_type          msg_pos;
   word_type          hdr_type;
   word_type          msg_len;
   word_type          data_off;
   word_type          pay_len;
   word_type          err_total;

   // Count the error, drop the rest of the transfer (or go idle at its end).
   function automatic payload_item_type frame_fault(input bit xfer_over);
      payload_item_type r;
      err_total = err_total + 1;
      state     = xfer_over ? ST_WAIT : ST_DROP;
      msg_pos   = '0;
      r         = '0;
      r.fault   = 1'b1;
      r.errors  = err_total;
      return r;
   endfunction

   // Advance the deframer by one byte; return 1 when the byte yields an item.
   function automatic bit deframe_byte(input byte_type b, input logic first,
                                       input tlen_type tlen,
                                       output payload_item_type r);
      logic [TL_W-1:0] tl;
      word_type        pos;
      bit              over;
      logic [63:0]     room;
      logic [63:0]     need;
      logic [63:0]     start;
      logic [63:0]     stop;
      r = '0;
      if (first) begin
         if (tlen == 0)
            tl = TL_W'(1);
         else if (tlen > MAX_TRANSFER_BYTES)
            tl = TL_W'(MAX_TRANSFER_BYTES);
         else
            tl = TL_W'(tlen);
         bytes_left = tl;
         state      = ST_HDR;
         msg_pos    = '0;
         hdr_type   = '0;
         msg_len    = '0;
         data_off   = '0;
         pay_len    = '0;
      end
      if (state == ST_WAIT || bytes_left == 0) begin
         state = ST_WAIT;
         return 1'b0;
      end
      bytes_left = bytes_left - 1'b1;
      over       = (bytes_left == 0);
      pos        = msg_pos;

      if (state == ST_DROP) begin
         if (over)
            state = ST_WAIT;
         return 1'b0;
      end

      if (state == ST_HDR) begin
         case (pos[3:2])
            2'd0: hdr_type[8*pos[1:0] +: 8] = b;
            2'd1: msg_len[8*pos[1:0] +: 8]  = b;
            2'd2: data_off[8*pos[1:0] +: 8] = b;
            default: pay_len[8*pos[1:0] +: 8] = b;
         endcase
         pos = pos + 1;
         if (pos < HDR_BYTES) begin
            if (over) begin
               r = frame_fault(1'b1);
               return 1'b1;
            end
            msg_pos = pos;
            return 1'b0;
         end
         room = 64'(HDR_BYTES) + 64'(bytes_left);
         need = 64'(data_off) + 64'(pay_len) + 64'd8;
         if (hdr_type != cfg_msg_type || 64'(msg_len) > room ||
             need > 64'(msg_len) || data_off < 8) begin
            r = frame_fault(over);
            return 1'b1;
         end
         if (msg_len == HDR_BYTES) begin
            msg_pos = '0;
            state   = over ? ST_WAIT : ST_HDR;
         end else begin
            msg_pos = HDR_BYTES;
            state   = over ? ST_WAIT : ST_PAYLOAD;
         end
         if (pay_len == 0) begin
            r.last   = 1'b1;
            r.errors = err_total;
            return 1'b1;
         end
         return 1'b0;
      end

      // message body: pass bytes inside the payload window, skip padding
      start = 64'(data_off) + 64'd8;
      stop  = start + 64'(pay_len);
      if (64'(pos) >= start && 64'(pos) < stop) begin
         r.data    = b;
         r.is_byte = 1'b1;
         r.last    = (64'(pos) + 64'd1 == stop);
         r.errors  = err_total;
         deframe_byte = 1'b1;
      end else begin
         deframe_byte = 1'b0;
      end
      pos = pos + 1;
      if (pos >= msg_len) begin
         msg_pos = '0;
         state   = over ? ST_WAIT : ST_HDR;
      end else begin
         msg_pos = pos;
         if (over)
            state = ST_WAIT;
      end
   endfunction

   function automatic int unsigned count_mismatches(input payload_item_type want,
                                                    input payload_item_type got);
      int unsigned n;
      n = 0;
      if (got.data !== want.data) begin
         $error("out_byte: expected %02h, got %02h", want.data, got.data);
         n++;
      end
      if (got.is_byte !== want.is_byte) begin
         $error("byte_valid: expected %0b, got %0b", want.is_byte, got.is_byte);
         n++;
      end
      if (got.last !== want.last) begin
         $error("last_of_packet: expected %0b, got %0b", want.last, got.last);
         n++;
      end
      if (got.fault !== want.fault) begin
         $error("frame_error: expected %0b, got %0b", want.fault, got.fault);
         n++;
      end
      if (got.errors !== want.errors) begin
         $error("error_count: expected %0d, got %0d", want.errors, got.errors);
         n++;
      end
      return n;
   endfunction

   always @(posedge clock) begin : watch
      payload_item_type predicted;
      payload_item_type seen;
      payload_item_type want;
      int unsigned      misses;
      misses = 0;
      if (reset) begin
         cfg_msg_type = 32'd1;
         state        = ST_WAIT;
         bytes_left   = '0;
         msg_pos      = '0;
         hdr_type     = '0;
         msg_len      = '0;
         data_off     = '0;
         pay_len      = '0;
         err_total    = '0;
         expected_items.delete();
         fail_count <= 0;
      end else begin
         // the byte at this edge still sees the old register value
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            if (deframe_byte(req_mon.data_byte, req_mon.first_of_transfer,
                             req_mon.transfer_length, predicted))
               expected_items.push_back(predicted);
         end
         if (psel && penable && pwrite && pready && paddr[2] == REG_PACKET_MSG_TYPE)
            cfg_msg_type = pwdata;
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            seen.data    = rsp_mon.out_byte;
            seen.is_byte = rsp_mon.byte_valid;
            seen.last    = rsp_mon.last_of_packet;
            seen.fault   = rsp_mon.frame_error;
            seen.errors  = rsp_mon.error_count;
            if (expected_items.size() == 0) begin
               $error("unexpected payload item: out_byte %02h frame_error %0b",
                      seen.data, seen.fault);
               misses = 1;
            end else begin
               want   = expected_items.pop_front();
               misses = count_mismatches(want, seen);
            end
         end
         fail_count <= fail_count + misses;
      end
      pending <= expected_items.size();
   end

endmodule

`default_nettype wire

// ===== verif/tb_rndis_rx_batch_deframer_top.sv =====
// ----------------------------------------------------------------------------
// tb_rndis_rx_batch_deframer_top: testbench of the batch packet deframer
// Feeds transfers of batched packet messages, good and malformed, through
// the byte channel with random gaps and payload-side stalls, rewrites the
// packet type register between phases, and leaves prediction and comparison
// to the payload checker instantiated beside the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_rndis_rx_batch_deframer_top;
   timeunit 1ns;
   timeprecision 1ps;
   import rrbd_pkg::*;

   // Cycles without any accepted item or bus access before the run is abandoned.
   localparam int unsigned  QUIET_LIMIT      = 2000;
   localparam csr_addr_type PACKET_TYPE_ADDR = {REG_PACKET_MSG_TYPE, 2'b00};

   // Ways a random transfer can be broken.
   typedef enum int unsigned {
      FLAW_NONE,
      FLAW_TYPE,         // header type differs from the register
      FLAW_TOO_LONG,     // message length beyond the bytes left in the transfer
      FLAW_OVERRUN,      // payload window runs past the message end
      FLAW_LOW_OFFSET,   // payload would start inside the header
      FLAW_WRAP_OFFSET,  // offset sum wraps in 32 bits
      FLAW_HUGE_LENGTH,  // payload length far past the message end
      FLAW_TRUNCATED,    // transfer ends inside a header
      FLAW_ABANDON       // transfer cut short by the next first byte
   } flaw_kind_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         psel;
   logic         penable;
   logic         pwrite;
   logic         pready;
   csr_addr_type paddr;
   csr_data_type pwdata;
   csr_data_type prdata;

   int unsigned  fail_count;
   int unsigned  pending;
   int unsigned  quiet_cycles = 0;

   // Stimulus knobs, flipped now and then so that stretches run without idling.
   bit           src_gaps;
   bit           sink_stalls;
   bit           open_transfer;
   word_type     msg_type_now;

   // The transfer being sent: its bytes, the length field and how many go out.
   byte_type     xfer_bytes[$];
   tlen_type     xfer_len;
   int unsigned  xfer_sent;

   rrbd_req_if req_ch();
   rrbd_rsp_if rsp_ch();

   rndis_rx_batch_deframer_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   rrbd_payload_checker scoreboard (
      .clock      (clock),
      .reset      (reset),
      .req_mon    (req_ch),
      .rsp_mon    (rsp_ch),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .pready     (pready),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Mostly short idle stretches, now and then a long one.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 2);
      if (r < 92)
         return $urandom_range(3, 6);
      return $urandom_range(10, 40);
   endfunction

   // Drive one byte at the falling edge, hold it until the block takes it.
   // transfer_length only matters on a first byte; scramble it elsewhere.
   task automatic push_byte(input byte_type value, input logic first, input tlen_type tlen);
      int unsigned gap;
      gap = (src_gaps && $urandom_range(0, 99) < 20) ? pick_gap() : 0;
      @(negedge clock);
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.valid             <= 1'b1;
      req_ch.data_byte         <= value;
      req_ch.first_of_transfer <= first;
      req_ch.transfer_length   <= first ? tlen : tlen_type'($urandom);
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
   endtask

   // Append a 16-byte little-endian header and the message body.
   task automatic add_message(input word_type mtype, input word_type mlen_f,
                              input word_type off_f, input word_type plen_f,
                              input int unsigned body);
      word_type hdr [4];
      hdr = '{mtype, mlen_f, off_f, plen_f};
      foreach (hdr[w])
         for (int k = 0; k < 4; k++)
            xfer_bytes.push_back(hdr[w][8*k +: 8]);
      repeat (body) xfer_bytes.push_back(byte_type'($urandom_range(0, 255)));
   endtask

   // Build one random transfer of one to three messages, sometimes broken.
   task automatic build_transfer(input bit may_abandon);
      flaw_kind_type flaw;
      int unsigned   nmsg;
      int unsigned   flaw_at;
      int unsigned   cut_at;
      int unsigned   plen;
      int unsigned   pre;
      int unsigned   post;
      int unsigned   pick;
      word_type      mtype;
      word_type      mlen_f;
      word_type      off_f;
      word_type      plen_f;
      xfer_bytes.delete();
      nmsg = $urandom_range(1, 3);
      flaw = FLAW_NONE;
      if ($urandom_range(0, 99) < 35)
         flaw = flaw_kind_type'($urandom_range(FLAW_TYPE, FLAW_ABANDON));
      if (flaw == FLAW_ABANDON && !may_abandon)
         flaw = FLAW_NONE;
      flaw_at = $urandom_range(0, nmsg - 1);
      cut_at  = 0;
      for (int m = 0; m < nmsg; m++) begin
         // keep payloads short; a rare long one stresses the body counter
         pick = $urandom_range(0, 99);
         if (pick < 12)
            plen = 0;
         else if (pick < 22)
            plen = 1;
         else if (pick < 97)
            plen = $urandom_range(2, 20);
         else
            plen = $urandom_range(60, 200);
         pre    = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
         post   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : 0;
         mtype  = msg_type_now;
         mlen_f = 16 + pre + plen + post;
         off_f  = 8 + pre;
         plen_f = plen;
         if (m == flaw_at) begin
            case (flaw)
               FLAW_TYPE:        mtype  = mtype ^ (32'd1 << $urandom_range(0, 31));
               FLAW_TOO_LONG:    mlen_f = $urandom_range(0, 1) ? {1'b1, 31'($urandom)} :
                                          32'(16400 + $urandom_range(0, 1000));
               FLAW_OVERRUN:     mlen_f = 8 + off_f + plen_f - $urandom_range(1, 3);
               FLAW_LOW_OFFSET:  off_f  = $urandom_range(0, 7);
               FLAW_WRAP_OFFSET: off_f  = 32'hFFFF_FFF8 + $urandom_range(0, 7);
               FLAW_HUGE_LENGTH: plen_f = 32'hFFFF_FF00 | $urandom_range(0, 255);
               FLAW_TRUNCATED:   cut_at = xfer_bytes.size() + $urandom_range(1, 15);
               default: ;
            endcase
         end
         add_message(mtype, mlen_f, off_f, plen_f, pre + plen + post);
      end
      // trailing bytes too few for a header end the transfer inside one
      if (flaw == FLAW_NONE && $urandom_range(0, 9) == 0)
         repeat ($urandom_range(1, 15))
            xfer_bytes.push_back(byte_type'($urandom_range(0, 255)));
      xfer_len  = tlen_type'(xfer_bytes.size());
      xfer_sent = xfer_bytes.size();
      if (flaw == FLAW_TRUNCATED) begin
         // a few bytes past the end land on an idle block and vanish
         xfer_len  = tlen_type'(cut_at);
         xfer_sent = cut_at + $urandom_range(0, 2);
         if (xfer_sent > xfer_bytes.size())
            xfer_sent = xfer_bytes.size();
      end
      if (flaw == FLAW_ABANDON) begin
         xfer_len  = ($urandom_range(0, 3) == 0) ?
                     tlen_type'($urandom_range(MAX_TRANSFER_BYTES, 32767)) :
                     tlen_type'(xfer_bytes.size() + $urandom_range(1, 40));
         xfer_sent = $urandom_range(1, xfer_bytes.size());
      end
      open_transfer = (flaw == FLAW_ABANDON);
   endtask

   task automatic send_transfer();
      for (int i = 0; i < xfer_sent; i++)
         push_byte(xfer_bytes[i], i == 0, xfer_len);
   endtask

   // Stream random transfers until the byte budget of the phase is spent,
   // then close any transfer left open so the block ends up idle.
   task automatic run_phase(input int unsigned n_items);
      int unsigned sent;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 3) == 0) begin
            src_gaps    = ($urandom_range(0, 2) != 0);
            sink_stalls = ($urandom_range(0, 2) != 0);
         end
         if ($urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, 3))
               push_byte(byte_type'($urandom_range(0, 255)), 1'b0, tlen_type'($urandom));
         build_transfer(1'b1);
         send_transfer();
         sent += xfer_sent;
      end
      if (open_transfer) begin
         build_transfer(1'b0);
         send_transfer();
      end
   endtask

   // Drop valid, wait for every queued item, then let the pipeline drain.
   task automatic settle(input int unsigned tail);
      @(negedge clock);
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (tail) @(posedge clock);
   endtask

   // Bus write: setup phase, then access phase until pready.
   task automatic csr_write(input word_type value);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= PACKET_TYPE_ADDR;
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (pready !== 1'b1) @(posedge clock);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      msg_type_now = value;
   endtask

   // Payload side: ready high by default, random stalls while enabled.
   initial begin
      int unsigned stall_left;
      stall_left   = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= 1'b1;
            if (sink_stalls && $urandom_range(0, 99) < 25)
               stall_left = pick_gap();
         end
      end
   end

   // Abort if nothing moves for too long: a lost item or a hung handshake.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) || (psel && penable))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   initial begin
      reset                    = 1'b1;
      psel                     = 1'b0;
      penable                  = 1'b0;
      pwrite                   = 1'b0;
      paddr                    = '0;
      pwdata                   = '0;
      req_ch.valid             = 1'b0;
      req_ch.data_byte         = '0;
      req_ch.first_of_transfer = 1'b0;
      req_ch.transfer_length   = '0;
      src_gaps                 = 1'b1;
      sink_stalls              = 1'b1;
      open_transfer            = 1'b0;
      msg_type_now             = 32'd1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: stray byte before any transfer is ignored.
      push_byte(8'hFF, 1'b0, 15'h7FFF);
      // Zero length counts as one byte, which ends inside the header.
      xfer_bytes = '{8'h00};
      xfer_len   = '0;
      xfer_sent  = 1;
      send_transfer();
      // Oversized length saturates; the transfer is then abandoned mid-header.
      xfer_bytes = '{8'h01, 8'h00};
      xfer_len   = 15'h7FFF;
      xfer_sent  = 2;
      send_transfer();
      // Header-only message with an empty payload gives one marker item.
      xfer_bytes.delete();
      add_message(msg_type_now, 32'd16, 32'd8, 32'd0, 0);
      xfer_len  = 15'd16;
      xfer_sent = 16;
      send_transfer();
      // Short transfer ends inside the header.
      xfer_bytes = '{8'h01, 8'h00, 8'h00};
      xfer_len   = 15'd3;
      xfer_sent  = 3;
      send_transfer();
      settle(4);

      // Random phases, each under a different packet type, extremes included.
      csr_write(32'hFFFF_FFFF);
      run_phase(230);
      settle(4);
      csr_write(32'h0000_0000);
      run_phase(230);
      settle(4);
      csr_write(word_type'($urandom));
      run_phase(230);
      settle(4);
      csr_write(32'd1);
      run_phase(240);
      settle(8);

      if (fail_count == 0 && pending == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
